FILE: rtl/fas_pkg.sv
// Shared types and constants for the frame animation sequencer.
// No dependencies; the top level and fas_dur_ram import this package.
`timescale 1ns / 1ps

package fas_pkg;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 5;

    // 0.1 s and 0.0001 s in unsigned Q16.16.
    localparam logic [TIME_W-1:0] DEFAULT_DURATION = 32'd6554;
    localparam logic [TIME_W-1:0] MIN_DURATION     = 32'd7;
    localparam logic [COUNT_W-1:0] MAX_COUNT       = 5'd16;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_PLAY   = 3'd2,
        OP_STOP   = 3'd3,
        OP_REWIND = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT = 1'b0,
        REG_LOOP_ENABLE = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_CHECK = 1'b1
    } t_state;

    // Write request into the duration table.
    typedef struct packed {
        logic                 en;
        logic [POS_W-1:0]     addr;
        logic [TIME_W-1:0]    data;
    } t_dur_wr;

endpackage

FILE: rtl/fas_in_if.sv
// Input channel of the frame animation sequencer: valid/ready plus one command.
// Depends on nothing.
`timescale 1ns / 1ps

interface fas_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] delta_time;
    logic [3:0]  frame_index;
    logic [31:0] duration;

    modport source (output valid, operation, delta_time, frame_index, duration,
                    input ready);
    modport sink   (input valid, operation, delta_time, frame_index, duration,
                    output ready);
endinterface

FILE: rtl/fas_out_if.sv
// Output channel of the frame animation sequencer: valid/ready plus status.
// Depends on nothing.
`timescale 1ns / 1ps

interface fas_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] current_frame;
    logic       playing;
    logic       finished;

    modport source (output valid, current_frame, playing, finished, input ready);
    modport sink   (input valid, current_frame, playing, finished, output ready);
endinterface

FILE: rtl/frame_animation_sequencer.sv
// Top level of the frame animation sequencer: command decode, tick walker
// and status register. Uses fas_pkg, fas_in_if, fas_out_if and fas_dur_ram.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------
// in_ch     in   operation, delta_time, frame_index, duration
// out_ch    out  current_frame, playing, finished (one beat per input beat)
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, 0 frame_count, 1 loop_enable
//
// Write, play, stop, rewind, unknown codes and ignored ticks load the status
// beat at the edge that accepts the command. A running tick first makes N
// duration checks (1 up to FRAME_SLOTS) and loads its beat with the last one:
// the duration table is read one entry per cycle, the next entry being
// fetched speculatively while the current one is compared.
// One command is in flight at a time. Reset is synchronous and active low;
// it clears all control state and the table's written flags. A stalled
// output holds its beat, and the input is not taken until that beat leaves.

module frame_animation_sequencer #(
    parameter int unsigned FRAME_SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fas_in_if.sink                         in_ch,
    fas_out_if.source                      out_ch
);
    import fas_pkg::*;

    localparam int unsigned CHK_W = $clog2(FRAME_SLOTS + 1);

    // Configuration registers.
    logic [COUNT_W-1:0] r_frame_count;
    logic               r_loop_enable;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [TIME_W-1:0]  r_acc, n_acc;
    logic               r_run, n_run;
    logic [CHK_W-1:0]   r_chk, n_chk;

    // Output register.
    logic               r_out_vld;
    logic [POS_W-1:0]   r_out_frame;
    logic               r_out_play;
    logic               r_out_fin;

    logic               w_accept;
    logic               w_tick_go;
    logic               w_chk_done;
    logic               w_out_load;
    logic               w_fin;
    logic [COUNT_W-1:0] w_count;
    logic [COUNT_W-1:0] w_pos_inc;
    logic [POS_W-1:0]   w_last;
    logic [POS_W-1:0]   w_cand;
    logic [TIME_W:0]    w_sum;
    logic [TIME_W-1:0]  w_dur;
    logic [POS_W-1:0]   w_rd_addr;
    t_dur_wr            w_wr;
    logic [TIME_W-1:0]  w_rd_data;
    logic               w_rd_written;
    t_op                w_op;

    // A frame_count above the table depth acts as the full table.
    assign w_count   = (r_frame_count > MAX_COUNT) ? MAX_COUNT : r_frame_count;
    assign w_last    = POS_W'(w_count - COUNT_W'(1));
    assign w_pos_inc = {1'b0, r_pos} + COUNT_W'(1);
    // Entry to prefetch while the current one is compared.
    assign w_cand    = (w_pos_inc < w_count) ? w_pos_inc[POS_W-1:0] : '0;
    assign w_op      = t_op'(in_ch.operation);
    assign w_accept  = in_ch.valid && in_ch.ready;
    assign w_sum     = {1'b0, r_acc} + {1'b0, in_ch.delta_time};

    // Duration of the current frame: a frame outside the count has zero
    // duration, and an entry never written reads as the minimum duration.
    always_comb begin
        if ({1'b0, r_pos} >= w_count) begin
            w_dur = '0;
        end else if (w_rd_written) begin
            w_dur = w_rd_data;
        end else begin
            w_dur = MIN_DURATION;
        end
    end

    assign w_tick_go = (w_op == OP_TICK) && r_run && (w_count != '0)
                       && (in_ch.delta_time != '0);

    fas_dur_ram u_dur_ram (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_rd_addr    (w_rd_addr),
        .o_rd_data    (w_rd_data),
        .o_rd_written (w_rd_written)
    );

    // Datapath next values.
    always_comb begin
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_run      = r_run;
        n_chk      = r_chk;
        w_chk_done = 1'b0;
        w_out_load = 1'b0;
        w_wr.en    = 1'b0;
        w_wr.addr  = in_ch.frame_index;
        w_wr.data  = (in_ch.duration == '0) ? DEFAULT_DURATION : in_ch.duration;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_chk = '0;
                    case (w_op)
                        OP_TICK: begin
                            if (w_tick_go) begin
                                // Saturating add of the elapsed time.
                                n_acc = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
                            end else begin
                                w_out_load = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            w_wr.en    = ({1'b0, in_ch.frame_index} < w_count);
                            w_out_load = 1'b1;
                        end
                        OP_PLAY: begin
                            if (w_count != '0) begin
                                n_run = 1'b1;
                            end
                            w_out_load = 1'b1;
                        end
                        OP_STOP: begin
                            n_run      = 1'b0;
                            w_out_load = 1'b1;
                        end
                        OP_REWIND: begin
                            n_pos      = '0;
                            n_acc      = '0;
                            w_out_load = 1'b1;
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_chk      = r_chk + CHK_W'(1);
                w_chk_done = 1'b1;
                if (r_acc >= w_dur) begin
                    n_acc = r_acc - w_dur;
                    if (w_pos_inc < w_count) begin
                        n_pos      = w_pos_inc[POS_W-1:0];
                        w_chk_done = (r_chk == CHK_W'(FRAME_SLOTS - 1));
                    end else if (r_loop_enable) begin
                        n_pos      = '0;
                        w_chk_done = (r_chk == CHK_W'(FRAME_SLOTS - 1));
                    end else begin
                        // Last frame without looping: park and stop.
                        n_pos = w_last;
                        n_run = 1'b0;
                        n_acc = '0;
                    end
                end
                w_out_load = w_chk_done;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_tick_go) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_chk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State machine outputs: input ready and the table read address.
    always_comb begin
        in_ch.ready = 1'b0;
        w_rd_addr   = r_pos;
        case (r_state)
            S_IDLE: begin
                in_ch.ready = !r_out_vld || out_ch.ready;
                w_rd_addr   = r_pos;
            end
            S_CHECK: begin
                w_rd_addr = w_cand;
            end
            default: begin
            end
        endcase
    end

    assign w_fin = !r_loop_enable && !n_run && (w_count != '0) && (n_pos == w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_loop_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                REG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_acc     <= '0;
            r_run     <= 1'b0;
            r_chk     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_run   <= n_run;
            r_chk   <= n_chk;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_frame <= n_pos;
            r_out_play  <= n_run;
            r_out_fin   <= w_fin;
        end
    end

    assign out_ch.valid         = r_out_vld;
    assign out_ch.current_frame = r_out_frame;
    assign out_ch.playing       = r_out_play;
    assign out_ch.finished      = r_out_fin;

endmodule

FILE: rtl/fas_dur_ram.sv
// Frame duration table: 16 x 32 synchronous memory, one write and one
// registered read per cycle, with per-entry written flags. Uses fas_pkg.
`timescale 1ns / 1ps

module fas_dur_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fas_pkg::t_dur_wr            i_wr,
    input  logic [fas_pkg::POS_W-1:0]   i_rd_addr,
    output logic [fas_pkg::TIME_W-1:0]  o_rd_data,
    output logic                        o_rd_written
);
    import fas_pkg::*;

    logic [TIME_W-1:0]      r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_written;
    logic [TIME_W-1:0]      r_rd_data;
    logic                   r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            r_rd_written <= r_written[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_rd_written = r_rd_written;

endmodule
